@@ rtl/core/esfr_pkg.sv @@
package esfr_pkg;

   localparam int POS_W = 11;
   localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 11'd1514;
   localparam logic [POS_W-1:0] HDR_START       = 11'd14;
   localparam logic [POS_W-1:0] SEQ1_END        = 11'd19;
   localparam logic [POS_W-1:0] SEQ2_END        = 11'd23;
   localparam logic [POS_W-1:0] PAYLOAD_START   = 11'd25;

   localparam logic [3:0] LAST_MATCH_POS = 4'd13;

   localparam int MAC_W   = 48;
   localparam int ETYPE_W = 16;
   localparam int SEQ_W   = 32;
   localparam int LEN_W   = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DST_MAC   = 2'd0,
      CSR_SRC_MAC   = 2'd1,
      CSR_ETHERTYPE = 2'd2,
      CSR_RX_BASE   = 2'd3
   } esfr_csr_idx_type;

   localparam logic [MAC_W-1:0]   DST_MAC_RESET   = 48'hffff_ffff_ffff;
   localparam logic [MAC_W-1:0]   SRC_MAC_RESET   = 48'h0080_1064_0000;
   localparam logic [ETYPE_W-1:0] ETHERTYPE_RESET = 16'h88b5;

   localparam logic [2:0] PTYPE_ERROR = 3'd0;
   localparam logic [2:0] PTYPE_RESET = 3'd1;
   localparam logic [2:0] PTYPE_DATA  = 3'd2;
   localparam logic [2:0] PTYPE_ACK   = 3'd4;

   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   localparam int Q_DEPTH  = 8;
   localparam int Q_ADDR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = Q_ADDR_W + 1;

   typedef struct packed {
      logic              kind;
      logic [7:0]        data;
      logic [SEQ_W-1:0]  offset;
      logic              ok;
      logic [2:0]        ptype;
      logic [SEQ_W-1:0]  first_seq;
      logic [SEQ_W-1:0]  second_seq;
      logic [LEN_W-1:0]  length;
      logic              last;
   } esfr_result_type;

   // up to two results per input byte: a always used first
   typedef struct packed {
      logic            a_valid;
      logic            b_valid;
      esfr_result_type a;
      esfr_result_type b;
   } esfr_push_type;

   function automatic logic [2:0] map_type(input logic [7:0] b);
      logic [2:0] r;
      if (b >= {5'd0, PTYPE_RESET} && b <= {5'd0, PTYPE_ACK}) begin
         r = b[2:0];
      end else begin
         r = PTYPE_ERROR;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/ethernet_stream_frame_receiver_top.sv @@
// An accepted byte passes through the input register and is then parsed into the result queue,
// whose head drives rsp_; its results wait longer while the queue drains.
// Throughput: one byte per cycle; a frame-end byte with a payload result yields two
// results, so an 8-entry queue absorbs the extra one; req_tready drops before it can fill.
// Reset (synchronous, active high) restores the default MAC/ethertype/base registers,
// clears the frame state, and empties the input stage and the result queue.
module ethernet_stream_frame_receiver_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [esfr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [esfr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [7:0] rx_byte
   input  logic                                   req_tlast,   // frame_end
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] payload_byte, [39:8] stream_offset, [40] frame_ok, [43:41] packet_type,
   // [75:44] first_seq, [107:76] second_seq, [123:108] payload_length, [127:124] zero
   output logic [127:0]                           rsp_tdata,
   output logic                                   rsp_tuser,   // result_kind
   output logic                                   rsp_tlast    // last_of_run
);
   import esfr_pkg::*;

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   logic               accept;
   logic [Q_CNT_W:0]   committed;
   esfr_push_type      push;
   esfr_result_type    result;
   logic [Q_CNT_W-1:0] q_count;

   // reserve room for two results from the byte in the input register
   // and two more from the byte being accepted
   assign committed  = {1'b0, q_count} + (in_valid_ff ? (Q_CNT_W+1)'(2) : '0);
   assign req_tready = committed <= (Q_CNT_W+1)'(Q_DEPTH - 2);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   esfr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .in_end    (in_end_ff),
      .push      (push)
   );

   esfr_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result),
      .count      (q_count)
   );

   assign rsp_tdata = {4'b0000, result.length, result.second_seq, result.first_seq,
                       result.ptype, result.ok, result.offset, result.data};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

@@ rtl/core/esfr_parse.sv @@
module esfr_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [esfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [esfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              in_valid,
   input  logic [7:0]                        in_byte,
   input  logic                              in_end,
   output esfr_pkg::esfr_push_type           push
);
   import esfr_pkg::*;

   logic [MAC_W-1:0]   dst_mac_ff;
   logic [MAC_W-1:0]   src_mac_ff;
   logic [ETYPE_W-1:0] etype_ff;
   logic [SEQ_W-1:0]   rx_base_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             mismatch_ff, mismatch_in;
   logic [2:0]       type_ff, type_in;
   logic [SEQ_W-1:0] seq1_ff, seq1_in;
   logic [SEQ_W-1:0] seq2_ff, seq2_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;

   logic [111:0]     match_cat;
   logic [3:0]       match_sel;
   logic [7:0]       exp_byte;
   logic [SEQ_W-1:0] offset;
   logic             complete;
   esfr_result_type  summary;

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_mac_ff <= DST_MAC_RESET;
         src_mac_ff <= SRC_MAC_RESET;
         etype_ff   <= ETHERTYPE_RESET;
         rx_base_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (esfr_csr_idx_type'(csr_index))
            CSR_DST_MAC:   dst_mac_ff <= csr_wdata;
            CSR_SRC_MAC:   src_mac_ff <= csr_wdata;
            CSR_ETHERTYPE: etype_ff   <= csr_wdata[ETYPE_W-1:0];
            CSR_RX_BASE:   rx_base_ff <= csr_wdata[SEQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         mismatch_ff <= 1'b0;
         type_ff     <= '0;
         seq1_ff     <= '0;
         seq2_ff     <= '0;
         len_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         mismatch_ff <= mismatch_in;
         type_ff     <= type_in;
         seq1_ff     <= seq1_in;
         seq2_ff     <= seq2_in;
         len_ff      <= len_in;
         idx_ff      <= idx_in;
      end
   end

   // address/ethertype bytes in frame order, byte 0 in the top bits
   assign match_cat = {dst_mac_ff, src_mac_ff, etype_ff};
   assign match_sel = LAST_MATCH_POS - pos_ff[3:0];
   assign exp_byte  = match_cat[{match_sel, 3'b000} +: 8];
   assign offset    = seq1_ff - rx_base_ff + {{(SEQ_W-LEN_W){1'b0}}, idx_ff};

   always_comb begin
      pos_in      = pos_ff;
      mismatch_in = mismatch_ff;
      type_in     = type_ff;
      seq1_in     = seq1_ff;
      seq2_in     = seq2_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      push        = '0;
      summary     = '0;
      complete    = 1'b0;

      if (in_valid) begin
         if (pos_ff < MAX_FRAME_BYTES) begin
            priority if (pos_ff < HDR_START) begin
               if (exp_byte != in_byte) mismatch_in = 1'b1;
            end else if (pos_ff == HDR_START) begin
               type_in = map_type(in_byte);
            end else if (pos_ff < SEQ1_END) begin
               seq1_in = {seq1_ff[SEQ_W-9:0], in_byte};
            end else if (pos_ff < SEQ2_END) begin
               seq2_in = {seq2_ff[SEQ_W-9:0], in_byte};
            end else if (pos_ff < PAYLOAD_START) begin
               len_in = {len_ff[LEN_W-9:0], in_byte};
               idx_in = '0;
            end else begin
               if (!mismatch_ff && type_ff == PTYPE_DATA && idx_ff < len_ff) begin
                  idx_in = idx_ff + 1'b1;
                  if (!offset[SEQ_W-1]) begin
                     push.a_valid      = 1'b1;
                     push.a.kind       = RESULT_PAYLOAD;
                     push.a.data       = in_byte;
                     push.a.offset     = offset;
                     push.a.ok         = 1'b1;
                     push.a.ptype      = type_ff;
                     push.a.first_seq  = seq1_ff;
                     push.a.second_seq = seq2_ff;
                     push.a.length     = len_ff;
                     push.a.last       = !in_end;
                  end
               end
            end
            pos_in = pos_ff + 1'b1;
         end

         if (in_end) begin
            complete           = pos_in >= PAYLOAD_START;
            summary.kind       = RESULT_SUMMARY;
            summary.ok         = complete && !mismatch_in;
            summary.ptype      = complete ? type_in : PTYPE_ERROR;
            summary.first_seq  = complete ? seq1_in : '0;
            summary.second_seq = complete ? seq2_in : '0;
            summary.length     = complete ? len_in : '0;
            summary.last       = 1'b1;
            if (push.a_valid) begin
               push.b_valid = 1'b1;
               push.b       = summary;
            end else begin
               push.a_valid = 1'b1;
               push.a       = summary;
            end
            pos_in      = '0;
            mismatch_in = 1'b0;
            type_in     = '0;
            seq1_in     = '0;
            seq2_in     = '0;
            len_in      = '0;
            idx_in      = '0;
         end
      end
   end

endmodule

@@ rtl/core/esfr_rsp_queue.sv @@
module esfr_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  esfr_pkg::esfr_push_type         push,
   output logic                            out_valid,
   input  logic                            out_ready,
   output esfr_pkg::esfr_result_type       out_result,
   output logic [esfr_pkg::Q_CNT_W-1:0]    count
);
   import esfr_pkg::*;

   esfr_result_type     entry_ff [Q_DEPTH];
   logic [Q_ADDR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]  count_ff;
   logic [Q_ADDR_W-1:0] wr_next;
   logic                pop;

   assign pop        = out_valid && out_ready;
   assign wr_next    = wr_ptr_ff + 1'b1;
   assign out_valid  = count_ff != '0;
   assign out_result = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push.a_valid) entry_ff[wr_ptr_ff] <= push.a;
      if (push.b_valid) entry_ff[wr_next]   <= push.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + Q_ADDR_W'(push.a_valid) + Q_ADDR_W'(push.b_valid);
         rd_ptr_ff <= rd_ptr_ff + Q_ADDR_W'(pop);
         count_ff  <= count_ff + Q_CNT_W'(push.a_valid) + Q_CNT_W'(push.b_valid)
                      - Q_CNT_W'(pop);
      end
   end

endmodule
